// ===== rtl/core/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, types and state encodings for the binomial and
// permutation count core.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int ARG_BITS   = 8;
	localparam int FIELD_BITS = 8;
	localparam int VALUE_BITS = 63;
	localparam int PROD_BITS  = VALUE_BITS + ARG_BITS;
	localparam int CNT_BITS   = $clog2(PROD_BITS);

	localparam logic [VALUE_BITS-1:0] VALUE_MAX  = {VALUE_BITS{1'b1}};
	localparam logic [CNT_BITS-1:0]   DIV_LAST   = CNT_BITS'(PROD_BITS - 1);

	typedef logic [ARG_BITS-1:0]   arg_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [PROD_BITS-1:0]  prod_t;

	typedef struct packed {
		logic   start;
		logic   div_en;
		value_t a;
		arg_t   b;
		arg_t   d;
	} unit_cmd_t;

	typedef struct packed {
		logic   done;
		logic   ovf;
		value_t quo;
	} unit_stat_t;

	typedef struct packed {
		logic   valid;
		value_t value;
		logic   overflow;
		logic   bad_args;
	} res_t;

	typedef enum logic [1:0] {
		U_IDLE,
		U_DIV,
		U_DONE
	} unit_state_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_STEP,
		C_WAIT,
		C_RESULT
	} ctrl_state_t;

endpackage

// ===== rtl/core/bpc_req_if.sv =====
// ----------------------------------------------------------------------------
// bpc_req_if
// Request channel: mode, n and k with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpc_req_if
	import bpc_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [FIELD_BITS-1:0] total_count;
	logic [FIELD_BITS-1:0] chosen_count;

	modport source (output valid, kind, total_count, chosen_count, input ready);
	modport sink   (input valid, kind, total_count, chosen_count, output ready);
endinterface

// ===== rtl/core/bpc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bpc_rsp_if
// Response channel: count and flags with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpc_rsp_if
	import bpc_pkg::*;
;
	logic   valid;
	logic   ready;
	value_t value;
	logic   overflow;
	logic   bad_args;

	modport source (output valid, value, overflow, bad_args, input ready);
	modport sink   (input valid, value, overflow, bad_args, output ready);
endinterface

// ===== rtl/core/bpc_muldiv.sv =====
// ----------------------------------------------------------------------------
// bpc_muldiv
// Shared arithmetic unit: one registered multiply a*b, then an optional
// restoring divide by d, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpc_muldiv
	import bpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  unit_cmd_t  cmd,
	output unit_stat_t stat
);

	unit_state_t         state_q, state_d;
	prod_t               p_q;
	arg_t                rem_q;
	arg_t                d_q;
	logic [CNT_BITS-1:0] cnt_q;

	logic [ARG_BITS:0] rem_ext;
	logic [ARG_BITS:0] diff;
	logic              ge;

	assign rem_ext = {rem_q, p_q[PROD_BITS-1]};
	assign ge      = rem_ext >= {1'b0, d_q};
	assign diff    = rem_ext - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			U_IDLE: begin
				if (cmd.start) begin
					state_d = cmd.div_en ? U_DIV : U_DONE;
				end
			end
			U_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = U_DONE;
				end
			end
			U_DONE: begin
				state_d = U_IDLE;
			end
			default: begin
				state_d = U_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == U_IDLE && cmd.start) begin
			p_q   <= PROD_BITS'(cmd.a) * PROD_BITS'(cmd.b);
			d_q   <= cmd.d;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (state_q == U_DIV) begin
			p_q   <= {p_q[PROD_BITS-2:0], ge};
			rem_q <= ge ? diff[ARG_BITS-1:0] : rem_ext[ARG_BITS-1:0];
			cnt_q <= cnt_q + CNT_BITS'(1);
		end
	end

	assign stat.done = (state_q == U_DONE);
	assign stat.ovf  = |p_q[PROD_BITS-1:VALUE_BITS];
	assign stat.quo  = p_q[VALUE_BITS-1:0];

endmodule

// ===== rtl/core/bpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpc_ctrl
// Sequencer: takes a request, walks the factors through the shared unit
// and holds the finished count until the output stage takes it.
// ----------------------------------------------------------------------------
module bpc_ctrl
	import bpc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	bpc_req_if.sink       req,
	input  logic          res_ready,
	output res_t          res,
	output unit_cmd_t     cmd,
	input  unit_stat_t    stat
);

	ctrl_state_t state_q, state_d;
	logic        kind_q;
	arg_t        n_q;
	arg_t        kk_q;
	arg_t        i_q;
	value_t      acc_q;
	logic        ovf_q;
	logic        bad_q;

	arg_t n_in, k_in, nk_in, kk_in;
	logic bad_in;

	assign n_in   = ARG_BITS'(req.total_count);
	assign k_in   = ARG_BITS'(req.chosen_count);
	assign bad_in = k_in > n_in;
	assign nk_in  = n_in - k_in;
	assign kk_in  = (req.kind || k_in <= nk_in) ? k_in : nk_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		cmd.start  = 1'b0;
		cmd.div_en = ~kind_q;
		cmd.a      = acc_q;
		cmd.b      = n_q - i_q;
		cmd.d      = kind_q ? ARG_BITS'(1) : i_q + ARG_BITS'(1);
		res.valid    = 1'b0;
		res.value    = acc_q;
		res.overflow = ovf_q;
		res.bad_args = bad_q;
		unique case (state_q)
			C_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = bad_in ? C_RESULT : C_STEP;
				end
			end
			C_STEP: begin
				if (i_q == kk_q) begin
					state_d = C_RESULT;
				end else begin
					cmd.start = 1'b1;
					state_d   = C_WAIT;
				end
			end
			C_WAIT: begin
				if (stat.done) begin
					state_d = stat.ovf ? C_RESULT : C_STEP;
				end
			end
			C_RESULT: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = C_IDLE;
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && req.valid) begin
			kind_q <= req.kind;
			n_q    <= n_in;
			kk_q   <= kk_in;
			i_q    <= '0;
			acc_q  <= bad_in ? '0 : VALUE_BITS'(1);
			ovf_q  <= 1'b0;
			bad_q  <= bad_in;
		end else if (state_q == C_WAIT && stat.done) begin
			if (stat.ovf) begin
				acc_q <= VALUE_MAX;
				ovf_q <= 1'b1;
			end else begin
				acc_q <= stat.quo;
				i_q   <= i_q + ARG_BITS'(1);
			end
		end
	end

endmodule

// ===== rtl/core/binomial_and_permutation_count_core.sv =====
// ----------------------------------------------------------------------------
// binomial_and_permutation_count_core
// Returns C(n,k) or A(n,k) per request, saturated to 63 bits with flags.
// ----------------------------------------------------------------------------
//  port  dir   beat contents
//  req   sink  kind, total_count (n), chosen_count (k)
//  rsp   src   value, overflow, bad_args
//
//  C(n,k) runs min(k,n-k) factor rounds, each a multiply and a restoring
//  divide at one quotient bit per cycle in the shared unit; A(n,k) runs k
//  multiply-only rounds. A round that overflows ends the request at once.
//  req is taken only between requests; one finished beat waits in the
//  output register so the next request can start while rsp stalls.
//  Reset clears the sequencers and the output valid.
// ----------------------------------------------------------------------------
module binomial_and_permutation_count_core
	import bpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	bpc_req_if.sink   req,
	bpc_rsp_if.source rsp
);

	unit_cmd_t  cmd;
	unit_stat_t stat;
	res_t       res;
	logic       res_ready;
	logic       out_valid_q;
	value_t     value_q;
	logic       overflow_q;
	logic       bad_args_q;

	assign res_ready = ~out_valid_q | rsp.ready;

	bpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_ready (res_ready),
		.res       (res),
		.cmd       (cmd),
		.stat      (stat)
	);

	bpc_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			value_q    <= res.value;
			overflow_q <= res.overflow;
			bad_args_q <= res.bad_args;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.value    = value_q;
	assign rsp.overflow = overflow_q;
	assign rsp.bad_args = bad_args_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binomial_and_permutation_count_core. Requests with
// random mode, n and k go in over the req channel with random gaps; every
// response beat is checked field by field against an exact computation of
// C(n,k) or A(n,k) with saturation at 2^63-1 and the overflow and bad-argument
// flags. A long stall on the response side backs the core up into its input.
// ----------------------------------------------------------------------------
module testbench;
	import bpc_pkg::*;

	localparam logic   MODE_COMB   = 1'b0;
	localparam logic   MODE_PERM   = 1'b1;
	localparam int     RANDOM_REQS = 580;
	localparam int     HOLD_BEAT   = 40;
	localparam int     HOLD_CYCLES = 3000;
	localparam int     QUIET_FIRST = 300;
	localparam int     QUIET_LAST  = 360;
	localparam longint CYCLE_LIMIT = 25_000_000;

	typedef struct {
		value_t value;
		logic   overflow;
		logic   bad_args;
	} count_rsp_t;

	class count_book;
		count_rsp_t pending_counts[$];
		int         failures;

		function new();
			failures = 0;
		endfunction

		function automatic count_rsp_t predict_count(logic kind, arg_t n, arg_t k);
			count_rsp_t  r;
			logic [127:0] acc;
			int unsigned nn;
			int unsigned kk;
			int unsigned rounds;
			int unsigned i;
			r.value    = '0;
			r.overflow = 1'b0;
			r.bad_args = 1'b0;
			nn = 32'(n);
			kk = 32'(k);
			if (kk > nn) begin
				r.bad_args = 1'b1;
				return r;
			end
			acc = 128'd1;
			if (kind == MODE_COMB) begin
				rounds = (kk > nn - kk) ? nn - kk : kk;
				for (i = 0; i < rounds && !r.overflow; i++) begin
					acc = acc * 128'(nn - i) / 128'(i + 1);
					if (acc > {65'd0, VALUE_MAX})
						r.overflow = 1'b1;
				end
			end else begin
				for (i = 0; i < kk && !r.overflow; i++) begin
					acc = acc * 128'(nn - i);
					if (acc > {65'd0, VALUE_MAX})
						r.overflow = 1'b1;
				end
			end
			r.value = r.overflow ? VALUE_MAX : acc[VALUE_BITS-1:0];
			return r;
		endfunction

		function void note_request(logic kind, logic [FIELD_BITS-1:0] n,
				logic [FIELD_BITS-1:0] k);
			pending_counts.push_back(predict_count(kind, arg_t'(n), arg_t'(k)));
		endfunction

		function void check_result(value_t value, logic overflow, logic bad_args);
			count_rsp_t exp_rsp;
			if (pending_counts.size() == 0) begin
				$error("response beat with no request pending: value %0d", value);
				failures++;
				return;
			end
			exp_rsp = pending_counts.pop_front();
			if (value !== exp_rsp.value) begin
				$error("value mismatch: expected %0d, actual %0d", exp_rsp.value, value);
				failures++;
			end
			if (overflow !== exp_rsp.overflow) begin
				$error("overflow mismatch: expected %0d, actual %0d",
					exp_rsp.overflow, overflow);
				failures++;
			end
			if (bad_args !== exp_rsp.bad_args) begin
				$error("bad_args mismatch: expected %0d, actual %0d",
					exp_rsp.bad_args, bad_args);
				failures++;
			end
		endfunction

		function int pending();
			return pending_counts.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	longint    cycle_count;
	bit        quiet_phase;
	int        beats_seen;
	count_book book;

	bpc_req_if req_ch ();
	bpc_rsp_if rsp_ch ();

	binomial_and_permutation_count_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial cycle_count = 0;
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL binomial_and_permutation_count_core");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 20);
		else
			return $urandom_range(50, 200);
	endfunction

	task automatic send_req(input logic kind, input logic [FIELD_BITS-1:0] n,
			input logic [FIELD_BITS-1:0] k);
		int unsigned gap;
		gap = quiet_phase ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.kind         <= kind;
		req_ch.total_count  <= n;
		req_ch.chosen_count <= k;
		do @(posedge clk); while (!req_ch.ready);
		book.note_request(kind, n, k);
	endtask

	task automatic send_random_req();
		int unsigned r;
		logic        kind;
		int unsigned n;
		int unsigned k;
		r    = $urandom_range(0, 99);
		kind = 1'($urandom_range(0, 1));
		if (r < 40) begin
			n = $urandom_range(0, 70);
			k = $urandom_range(0, n);
		end else if (r < 60) begin
			n = $urandom_range(0, 255);
			k = $urandom_range(0, n);
		end else if (r < 72) begin
			kind = MODE_PERM;
			n    = $urandom_range(0, 24);
			k    = $urandom_range(0, n);
		end else if (r < 82) begin
			n = $urandom_range(0, 254);
			k = $urandom_range(n + 1, 255);
		end else begin
			n = $urandom_range(0, 255);
			k = $urandom_range(0, 255);
		end
		send_req(kind, n[FIELD_BITS-1:0], k[FIELD_BITS-1:0]);
	endtask

	initial begin : rsp_sink
		int unsigned hold_left;
		hold_left    = 0;
		beats_seen   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				book.check_result(rsp_ch.value, rsp_ch.overflow, rsp_ch.bad_args);
				beats_seen++;
				if (beats_seen == HOLD_BEAT)
					hold_left = HOLD_CYCLES;
				else
					hold_left = quiet_phase ? 0 : pick_gap();
			end
		end
	end

	initial begin : stimulus
		book                = new();
		quiet_phase         = 1'b0;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.kind         = MODE_COMB;
		req_ch.total_count  = '0;
		req_ch.chosen_count = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// edges of n and k, bad arguments, largest exact and first saturating cases
		send_req(MODE_COMB, 8'd0,   8'd0);
		send_req(MODE_PERM, 8'd0,   8'd0);
		send_req(MODE_COMB, 8'd255, 8'd0);
		send_req(MODE_PERM, 8'd255, 8'd0);
		send_req(MODE_COMB, 8'd255, 8'd255);
		send_req(MODE_PERM, 8'd255, 8'd255);
		send_req(MODE_COMB, 8'd0,   8'd1);
		send_req(MODE_PERM, 8'd0,   8'd255);
		send_req(MODE_COMB, 8'd254, 8'd255);
		send_req(MODE_PERM, 8'd127, 8'd128);
		send_req(MODE_COMB, 8'd1,   8'd1);
		send_req(MODE_PERM, 8'd1,   8'd1);
		send_req(MODE_COMB, 8'd255, 8'd1);
		send_req(MODE_PERM, 8'd255, 8'd1);
		send_req(MODE_COMB, 8'd255, 8'd254);
		send_req(MODE_COMB, 8'd255, 8'd127);
		send_req(MODE_PERM, 8'd255, 8'd128);
		send_req(MODE_COMB, 8'd66,  8'd33);
		send_req(MODE_COMB, 8'd67,  8'd33);
		send_req(MODE_COMB, 8'd62,  8'd31);
		send_req(MODE_PERM, 8'd20,  8'd20);
		send_req(MODE_PERM, 8'd21,  8'd21);
		send_req(MODE_COMB, 8'd10,  8'd3);
		send_req(MODE_PERM, 8'd10,  8'd3);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			quiet_phase = (i >= QUIET_FIRST && i < QUIET_LAST);
			send_random_req();
		end
		quiet_phase = 1'b0;
		@(negedge clk);
		req_ch.valid <= 1'b0;

		while (book.pending() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (book.failures == 0)
			$display("PASS binomial_and_permutation_count_core");
		else
			$display("FAIL binomial_and_permutation_count_core");
		$finish;
	end

endmodule
